>>> rtl/dsc_pkg.sv
// Shared types, constants and helpers for the deadlock safety check.
// No dependencies; imported by every module of the block.
package dsc_pkg;

    localparam int NUM_RES         = 3;
    localparam int FIELD_W         = 8;
    localparam int AVAIL_W         = 12;
    localparam int PROC_W          = 4;
    localparam int DEF_NUM_PROCS   = 8;
    localparam int DEF_COUNT_WIDTH = 8;

    localparam logic [AVAIL_W-1:0] AVAIL_MAX = {AVAIL_W{1'b1}};

    typedef logic [FIELD_W-1:0] t_cnt;
    typedef logic [AVAIL_W-1:0] t_avail;

    // Opcodes of an input transfer
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // One process row as read from the row store
    typedef struct packed {
        t_cnt [NUM_RES-1:0] alloc;
        t_cnt [NUM_RES-1:0] need;
    } t_row;

    // Result of the shared compare/add unit
    typedef struct packed {
        logic                 fits;
        t_avail [NUM_RES-1:0] sum;
    } t_alu_res;

    // Need is claim minus allocation, floored at zero
    function automatic t_cnt need_of(input t_cnt claim, input t_cnt alloc);
        need_of = (claim > alloc) ? t_cnt'(claim - alloc) : '0;
    endfunction

endpackage

>>> rtl/dsc_row_store.sv
// Row store: allocation and need per process, written by load transfers.
// Depends on dsc_pkg.
module dsc_row_store
    import dsc_pkg::*;
#(
    parameter int NUM_PROCS   = DEF_NUM_PROCS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_wr_en,
    input  logic [(NUM_PROCS > 1 ? $clog2(NUM_PROCS) : 1)-1:0] i_wr_addr,
    input  t_cnt [NUM_RES-1:0]                           i_alloc,
    input  t_cnt [NUM_RES-1:0]                           i_claim,
    input  logic [(NUM_PROCS > 1 ? $clog2(NUM_PROCS) : 1)-1:0] i_rd_addr,
    output t_row                                         o_row
);

    localparam int   CW       = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;
    localparam t_cnt CNT_MASK = t_cnt'((1 << CW) - 1);

    t_row r_rows [NUM_PROCS];
    t_row n_row;

    // Mask counts and form the need of the incoming row
    always_comb begin
        for (int r = 0; r < NUM_RES; r++) begin
            n_row.alloc[r] = i_alloc[r] & CNT_MASK;
            n_row.need[r]  = need_of(i_claim[r] & CNT_MASK, i_alloc[r] & CNT_MASK);
        end
    end

    // Hold rows; clear all of them at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PROCS; p++) begin
                r_rows[p] <= '0;
            end
        end else if (i_wr_en) begin
            r_rows[i_wr_addr] <= n_row;
        end
    end

    assign o_row = r_rows[i_rd_addr];

endmodule

>>> rtl/dsc_alu.sv
// Shared compare/add unit: tests a need row against available and forms
// the saturated sum of available and allocation. Depends on dsc_pkg.
module dsc_alu
    import dsc_pkg::*;
(
    input  t_row                 i_row,
    input  t_avail [NUM_RES-1:0] i_avail,
    output t_alu_res             o_res
);

    logic [AVAIL_W:0] sum_w [NUM_RES];
    logic [NUM_RES-1:0] fit_r;

    // Compare each resource and add with saturation
    always_comb begin
        for (int r = 0; r < NUM_RES; r++) begin
            fit_r[r]  = t_avail'(i_row.need[r]) <= i_avail[r];
            sum_w[r]  = {1'b0, i_avail[r]} + (AVAIL_W+1)'(i_row.alloc[r]);
            o_res.sum[r] = sum_w[r][AVAIL_W] ? AVAIL_MAX : sum_w[r][AVAIL_W-1:0];
        end
        o_res.fits = &fit_r;
    end

endmodule

>>> rtl/deadlock_safety_check.sv
// Top level of the deadlock safety check: command port, scan sequencer.
// Depends on dsc_pkg, dsc_row_store and dsc_alu.
//
// Usage: drive the input ports and raise start while busy is low; the
// transfer is taken at that clock edge. A load (opcode 0) writes one
// process row and leaves busy low, so loads may follow every
// cycle. A run (opcode 1) raises busy and scans the process rows, one row
// per cycle through a single shared compare/add unit, pass after pass.
// Each completed process gives one result with o_valid high for one cycle,
// the cycle after the row was examined. A pass that completes nobody ends
// the run with an unsafe result (o_finished_proc 0, o_safe 0, o_last 1).
// The number of passes a run makes is set by how the completions unlock.
// busy drops on the cycle the final result appears.
// The receiver cannot stall: results are presented once and never held.
// Reset (i_rst_n low, synchronous) clears all rows, done marks and the
// available vector and returns the sequencer to idle.
module deadlock_safety_check
    import dsc_pkg::*;
#(
    parameter int NUM_PROCS   = DEF_NUM_PROCS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [2:0]         i_proc_index,
    input  logic [FIELD_W-1:0] i_alloc_a,
    input  logic [FIELD_W-1:0] i_alloc_b,
    input  logic [FIELD_W-1:0] i_alloc_c,
    input  logic [FIELD_W-1:0] i_claim_a,
    input  logic [FIELD_W-1:0] i_claim_b,
    input  logic [FIELD_W-1:0] i_claim_c,
    input  logic [FIELD_W-1:0] i_free_a,
    input  logic [FIELD_W-1:0] i_free_b,
    input  logic [FIELD_W-1:0] i_free_c,
    output logic               o_valid,
    output logic [PROC_W-1:0]  o_finished_proc,
    output logic               o_safe,
    output logic [AVAIL_W-1:0] o_avail_a,
    output logic [AVAIL_W-1:0] o_avail_b,
    output logic [AVAIL_W-1:0] o_avail_c,
    output logic               o_last
);

    localparam int IW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNW = $clog2(NUM_PROCS + 1);
    localparam int CW  = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;

    localparam logic [IW-1:0]  LAST_PTR  = IW'(NUM_PROCS - 1);
    localparam logic [CNW-1:0] LAST_CNT  = CNW'(NUM_PROCS - 1);
    localparam logic [4:0]     NP5       = 5'(NUM_PROCS);
    localparam t_cnt           CNT_MASK  = t_cnt'((1 << CW) - 1);

    t_state r_state, n_state;

    logic [IW-1:0]        r_ptr;
    logic [CNW-1:0]       r_cnt;
    logic                 r_prog;
    logic [NUM_PROCS-1:0] r_done;
    t_avail [NUM_RES-1:0] r_avail;

    logic               accept, load_go, run_go;
    logic [4:0]         idx5;
    logic [4:0]         proc5;
    t_row               row;
    t_alu_res           alu;
    logic               scanning, take, pass_end, all_done, unsafe;
    t_cnt [NUM_RES-1:0] alloc_in, claim_in;
    t_avail [NUM_RES-1:0] free_in;

    // Decode the command transfer
    assign accept  = start && !busy;
    assign load_go = accept && (i_opcode == OP_LOAD) && (idx5 < NP5);
    assign run_go  = accept && (i_opcode == OP_RUN);
    assign idx5    = {2'b00, i_proc_index};

    assign alloc_in = {i_alloc_c, i_alloc_b, i_alloc_a};
    assign claim_in = {i_claim_c, i_claim_b, i_claim_a};
    assign free_in  = {t_avail'(i_free_c & CNT_MASK), t_avail'(i_free_b & CNT_MASK),
                       t_avail'(i_free_a & CNT_MASK)};

    dsc_row_store #(
        .NUM_PROCS   (NUM_PROCS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (load_go),
        .i_wr_addr (idx5[IW-1:0]),
        .i_alloc   (alloc_in),
        .i_claim   (claim_in),
        .i_rd_addr (r_ptr),
        .o_row     (row)
    );

    dsc_alu u_alu (
        .i_row   (row),
        .i_avail (r_avail),
        .o_res   (alu)
    );

    // Decisions for the row under the scan pointer
    assign take     = scanning && !r_done[r_ptr] && alu.fits;
    assign pass_end = (r_ptr == LAST_PTR);
    assign all_done = take && (r_cnt == LAST_CNT);
    assign unsafe   = scanning && pass_end && !take && !r_prog;
    assign proc5    = 5'(r_ptr) + 5'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (run_go) n_state = ST_SCAN;
            ST_SCAN: if (all_done || unsafe) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        unique case (r_state)
            ST_SCAN: begin
                busy     = 1'b1;
                scanning = 1'b1;
            end
            default: begin
                busy     = 1'b0;
                scanning = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan state: pointer, completion count, pass progress, done marks, available
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_prog  <= 1'b0;
            r_done  <= '0;
            r_avail <= '0;
        end else if (run_go) begin
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_prog  <= 1'b0;
            r_done  <= '0;
            r_avail <= free_in;
        end else if (scanning) begin
            r_ptr  <= pass_end ? '0 : r_ptr + 1'b1;
            r_prog <= pass_end ? 1'b0 : (r_prog || take);
            if (take) begin
                r_done[r_ptr] <= 1'b1;
                r_cnt         <= r_cnt + 1'b1;
                r_avail       <= alu.sum;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= take || unsafe;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take || unsafe) begin
            o_finished_proc <= take ? proc5[PROC_W-1:0] : '0;
            o_safe          <= all_done;
            o_last          <= all_done || unsafe;
            o_avail_a       <= take ? alu.sum[0] : r_avail[0];
            o_avail_b       <= take ? alu.sum[1] : r_avail[1];
            o_avail_c       <= take ? alu.sum[2] : r_avail[2];
        end
    end

    // A final result always returns the sequencer to idle
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("final result while still scanning");

    // Results only come out of a scan
    a_valid_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a scan");

    // Safe is only reported on the final result
    a_safe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_safe |-> o_last)
        else $error("safe flag on a non-final result");

    // Whenever busy falls, a final result is presented with it
    a_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid && o_last)
        else $error("scan ended without a final result");

endmodule

>>> verif/tb_deadlock_safety_check.sv
// Self-checking testbench for the deadlock safety check: directed and random commands.
// Holds its own prediction of the Banker's safety scan and checks every result transfer.
// Depends on dsc_pkg and the deadlock_safety_check RTL.
module tb_deadlock_safety_check import dsc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PROCS   = DEF_NUM_PROCS;
    localparam int COUNT_WIDTH = DEF_COUNT_WIDTH;
    localparam int TAIL_CYCLES = NUM_PROCS * NUM_PROCS + 16;

    // One command transfer; index 0 is resource A, 1 is B, 2 is C
    typedef struct packed {
        logic                 op;
        logic [2:0]           idx;
        t_cnt [NUM_RES-1:0]   alloc;
        t_cnt [NUM_RES-1:0]   claim;
        t_cnt [NUM_RES-1:0]   free;
    } t_cmd;

    // One completion as the block reports it
    typedef struct packed {
        logic [PROC_W-1:0]    proc;
        logic                 safe;
        t_avail [NUM_RES-1:0] avail;
        logic                 last;
    } t_completion;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_opcode;
    logic [2:0]         i_proc_index;
    t_cnt               i_alloc_a, i_alloc_b, i_alloc_c;
    t_cnt               i_claim_a, i_claim_b, i_claim_c;
    t_cnt               i_free_a, i_free_b, i_free_c;
    logic               o_valid;
    logic [PROC_W-1:0]  o_finished_proc;
    logic               o_safe;
    t_avail             o_avail_a, o_avail_b, o_avail_c;
    logic               o_last;

    // Predicted block state
    t_cnt [NUM_RES-1:0]     held_units [NUM_PROCS];
    t_cnt [NUM_RES-1:0]     owed_units [NUM_PROCS];
    t_avail [NUM_RES-1:0]   pool;
    logic [NUM_PROCS-1:0]   finished;

    t_completion            pending_completions [$];
    int                     mismatches;
    int                     items_sent;

    deadlock_safety_check #(
        .NUM_PROCS   (NUM_PROCS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_proc_index    (i_proc_index),
        .i_alloc_a       (i_alloc_a),
        .i_alloc_b       (i_alloc_b),
        .i_alloc_c       (i_alloc_c),
        .i_claim_a       (i_claim_a),
        .i_claim_b       (i_claim_b),
        .i_claim_c       (i_claim_c),
        .i_free_a        (i_free_a),
        .i_free_b        (i_free_b),
        .i_free_c        (i_free_c),
        .o_valid         (o_valid),
        .o_finished_proc (o_finished_proc),
        .o_safe          (o_safe),
        .o_avail_a       (o_avail_a),
        .o_avail_b       (o_avail_b),
        .o_avail_c       (o_avail_c),
        .o_last          (o_last)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2ms;
        $display("tb_deadlock_safety_check: done, errors");
        $finish;
    end

    // Store one process row: need is claim minus allocation, floored at zero
    task automatic store_row(input t_cmd c);
        if (c.idx < NUM_PROCS) begin
            for (int k = 0; k < NUM_RES; k++) begin
                held_units[c.idx][k] = c.alloc[k];
                owed_units[c.idx][k] = (c.claim[k] > c.alloc[k]) ? t_cnt'(c.claim[k] - c.alloc[k])
                                                                 : '0;
            end
        end
    endtask

    // Walk the safety scan pass by pass and queue every completion it reports
    task automatic predict_scan(input t_cmd c);
        int                  completed;
        logic                progress;
        logic                fit;
        logic                ended;
        logic [AVAIL_W:0]    total;
        t_completion         res;
        for (int k = 0; k < NUM_RES; k++)
            pool[k] = t_avail'(c.free[k]);
        finished  = '0;
        completed = 0;
        ended     = 1'b0;
        while (!ended) begin
            progress = 1'b0;
            for (int p = 0; p < NUM_PROCS; p++) begin
                if (!ended && !finished[p]) begin
                    fit = 1'b1;
                    for (int k = 0; k < NUM_RES; k++)
                        if (t_avail'(owed_units[p][k]) > pool[k])
                            fit = 1'b0;
                    if (fit) begin
                        finished[p] = 1'b1;
                        for (int k = 0; k < NUM_RES; k++) begin
                            total   = {1'b0, pool[k]} + (AVAIL_W + 1)'(held_units[p][k]);
                            pool[k] = (total > {1'b0, AVAIL_MAX}) ? AVAIL_MAX
                                                                  : total[AVAIL_W-1:0];
                        end
                        completed++;
                        progress  = 1'b1;
                        res.proc  = PROC_W'(p + 1);
                        res.safe  = (completed == NUM_PROCS);
                        res.last  = (completed == NUM_PROCS);
                        res.avail = pool;
                        pending_completions.push_back(res);
                        if (completed == NUM_PROCS)
                            ended = 1'b1;
                    end
                end
            end
            // A pass with no completion ends the run as unsafe
            if (!ended && !progress) begin
                res.proc  = '0;
                res.safe  = 1'b0;
                res.last  = 1'b1;
                res.avail = pool;
                pending_completions.push_back(res);
                ended = 1'b1;
            end
        end
    endtask

    // Drive one command from the falling edge and hold it until the block takes it
    task automatic send_cmd(input t_cmd c);
        @(negedge i_clk);
        i_opcode     <= c.op;
        i_proc_index <= c.idx;
        i_alloc_a    <= c.alloc[0];
        i_alloc_b    <= c.alloc[1];
        i_alloc_c    <= c.alloc[2];
        i_claim_a    <= c.claim[0];
        i_claim_b    <= c.claim[1];
        i_claim_c    <= c.claim[2];
        i_free_a     <= c.free[0];
        i_free_b     <= c.free[1];
        i_free_c     <= c.free[2];
        start        <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0)
                break;
        end
        if (c.op == OP_LOAD)
            store_row(c);
        else
            predict_scan(c);
        items_sent++;
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold the sender until every queued completion has arrived
    task automatic drain_results();
        hold_off(1);
        while (pending_completions.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_cmd make_load(input logic [2:0] idx,
                                       input t_cnt a, input t_cnt b, input t_cnt c,
                                       input t_cnt ca, input t_cnt cb, input t_cnt cc);
        t_cmd cmd;
        cmd.op    = OP_LOAD;
        cmd.idx   = idx;
        cmd.alloc = {c, b, a};
        cmd.claim = {cc, cb, ca};
        cmd.free  = {t_cnt'($urandom), t_cnt'($urandom), t_cnt'($urandom)};
        return cmd;
    endfunction

    function automatic t_cmd make_run(input t_cnt fa, input t_cnt fb, input t_cnt fc);
        t_cmd cmd;
        cmd.op    = OP_RUN;
        cmd.idx   = 3'($urandom);
        cmd.alloc = {t_cnt'($urandom), t_cnt'($urandom), t_cnt'($urandom)};
        cmd.claim = {t_cnt'($urandom), t_cnt'($urandom), t_cnt'($urandom)};
        cmd.free  = {fc, fb, fa};
        return cmd;
    endfunction

    // Random row: claims mostly near the allocation so that runs can progress
    function automatic t_cmd random_load(input logic [2:0] idx);
        t_cmd cmd;
        int   wide;
        cmd = make_run(8'd0, 8'd0, 8'd0);
        cmd.op  = OP_LOAD;
        cmd.idx = idx;
        for (int k = 0; k < NUM_RES; k++) begin
            cmd.alloc[k] = t_cnt'($urandom);
            cmd.free[k]  = t_cnt'($urandom);
            case ($urandom_range(0, 2))
                0: cmd.claim[k] = t_cnt'($urandom);
                1: cmd.claim[k] = cmd.alloc[k] - t_cnt'($urandom_range(0, 60));
                default: begin
                    wide = int'(cmd.alloc[k]) + $urandom_range(0, 40);
                    cmd.claim[k] = (wide > 255) ? t_cnt'(255) : t_cnt'(wide);
                end
            endcase
        end
        return cmd;
    endfunction

    function automatic t_cmd random_run();
        t_cmd cmd;
        cmd = make_run(8'd0, 8'd0, 8'd0);
        for (int k = 0; k < NUM_RES; k++)
            case ($urandom_range(0, 3))
                0:       cmd.free[k] = '0;
                1:       cmd.free[k] = t_cnt'($urandom_range(0, 20));
                default: cmd.free[k] = t_cnt'($urandom);
            endcase
        return cmd;
    endfunction

    task automatic maybe_gap(input bit gaps_on);
        if (gaps_on && $urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 17));
    endtask

    // All rows zero after reset: every process completes in the first pass
    task automatic test_run_after_reset();
        send_cmd(make_run(8'd255, 8'd0, 8'd170));
    endtask

    // Field extremes, claims below and above the allocation, sums past 8 bits
    task automatic test_field_extremes();
        send_cmd(make_load(3'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
        send_cmd(make_load(3'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        send_cmd(make_load(3'd2, 8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA));
        send_cmd(make_load(3'd3, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55));
        send_cmd(make_run(8'd0, 8'd0, 8'd0));
    endtask

    // Rows unlock in reverse order: one completion per pass, longest scan
    task automatic test_unlock_chain();
        for (int p = 0; p < NUM_PROCS; p++)
            send_cmd(make_load(3'(p), 8'd10, 8'd10, 8'd10, t_cnt'(10 + (7 - p) * 10),
                               t_cnt'(10 + (7 - p) * 10), t_cnt'(10 + (7 - p) * 10)));
        send_cmd(make_run(8'd0, 8'd0, 8'd0));
    endtask

    // Nobody fits at the start: the unsafe result is the only one
    task automatic test_no_starter();
        for (int p = 0; p < NUM_PROCS; p++)
            send_cmd(make_load(3'(p), 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        send_cmd(make_run(8'd254, 8'd255, 8'd255));
    endtask

    // One process completes, then a pass stalls and the run ends unsafe
    task automatic test_partial_then_unsafe();
        send_cmd(make_load(3'd3, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200));
        send_cmd(make_run(8'd0, 8'd0, 8'd0));
    endtask

    // Mostly row loads followed by a run, with some stray single commands
    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        int   target;
        int   rows;
        bit   gaps_on;
        t_cmd cmd;
        target = items_sent + n_items;
        while (items_sent < target) begin
            gaps_on = with_gaps && ($urandom_range(0, 1) == 1);
            if ($urandom_range(0, 9) < 8) begin
                rows = $urandom_range(1, NUM_PROCS);
                repeat (rows) begin
                    maybe_gap(gaps_on);
                    send_cmd(random_load(3'($urandom_range(0, NUM_PROCS - 1))));
                end
                maybe_gap(gaps_on);
                send_cmd(random_run());
            end else begin
                maybe_gap(gaps_on);
                cmd = ($urandom_range(0, 1) == 1) ? random_run() : random_load(3'($urandom));
                send_cmd(cmd);
            end
        end
    endtask

    function automatic void check_field(input string name, input int expd, input int actual);
        if (expd != actual) begin
            $error("%s: expected %0d, got %0d", name, expd, actual);
            mismatches++;
        end
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_completion want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_completions.size() == 0) begin
                $error("result with none expected: finished_proc %0d", o_finished_proc);
                mismatches++;
            end else begin
                want = pending_completions.pop_front();
                check_field("finished_proc", int'(want.proc), int'(o_finished_proc));
                check_field("safe", int'(want.safe), int'(o_safe));
                check_field("avail_a", int'(want.avail[0]), int'(o_avail_a));
                check_field("avail_b", int'(want.avail[1]), int'(o_avail_b));
                check_field("avail_c", int'(want.avail[2]), int'(o_avail_c));
                check_field("last", int'(want.last), int'(o_last));
            end
        end
    end

    // Test sequence
    initial begin
        mismatches   = 0;
        items_sent   = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_opcode     = OP_LOAD;
        i_proc_index = '0;
        {i_alloc_a, i_alloc_b, i_alloc_c} = '0;
        {i_claim_a, i_claim_b, i_claim_c} = '0;
        {i_free_a, i_free_b, i_free_c}    = '0;
        for (int p = 0; p < NUM_PROCS; p++) begin
            held_units[p] = '0;
            owed_units[p] = '0;
        end
        pool     = '0;
        finished = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_run_after_reset();
        test_field_extremes();
        test_unlock_chain();
        test_no_starter();
        test_partial_then_unsafe();
        test_random_traffic(35, 1'b1);
        // Let the block go fully idle before sending more
        drain_results();
        test_random_traffic(30, 1'b1);
        test_random_traffic(20, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_deadlock_safety_check: done, clean");
        else
            $display("tb_deadlock_safety_check: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/dsc_pkg.sv
rtl/dsc_row_store.sv
rtl/dsc_alu.sv
rtl/deadlock_safety_check.sv
verif/tb_deadlock_safety_check.sv
